/* src/sre_pkg.sv */
// Shared types and constants for the stack with range edit.
`timescale 1ns / 1ps

package sre_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FUNC_W         = 3;

  localparam logic [FUNC_W-1:0] FUNC_PUSH   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd4;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_RD_WAIT,
    S_REMOVE,
    S_SEARCH,
    S_SHIFT,
    S_PLACE
  } ctl_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PUSH,
    OP_POP,
    OP_RD_ISSUE,
    OP_RM_SETUP,
    OP_RM_STEP,
    OP_SR_SETUP,
    OP_SR_STEP,
    OP_SH_STEP,
    OP_PLACE
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    logic    finish;
    status_e code;
    logic    use_rdata;
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              full;
    logic              empty;
    logic              rd_ok;
    logic              rm_bad;
    logic              rm_none;
    logic              mv_done;
    logic              sr_done;
    logic              sh_done;
  } dp_stat_t;

endpackage

/* src/sre_datapath.sv */
// Datapath: entry store, entry count, walk pointers and result registers.
`timescale 1ns / 1ps

module sre_datapath #(
  parameter int DEPTH      = sre_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = sre_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [sre_pkg::FUNC_W-1:0]         func_i,
  input  logic signed [DATA_WIDTH-1:0]       value_i,
  input  logic [$clog2(DEPTH+1)-1:0]         position_i,
  input  logic [$clog2(DEPTH+1)-1:0]         remove_count_i,
  input  logic signed [DATA_WIDTH-1:0]       match_value_i,
  input  sre_pkg::dp_cmd_t                   cmd_i,
  output sre_pkg::dp_stat_t                  stat_o,
  output logic                               done_o,
  output logic signed [DATA_WIDTH-1:0]       read_data_o,
  output logic [$clog2(DEPTH+1)-1:0]         entry_total_o,
  output logic [1:0]                         status_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [DATA_WIDTH-1:0]      mem [DEPTH];
  logic [DATA_WIDTH-1:0]      mem_rd_q;

  logic [sre_pkg::FUNC_W-1:0] func_q;
  logic [DATA_WIDTH-1:0]      value_q;
  logic [DATA_WIDTH-1:0]      match_q;
  logic [CW-1:0]              pos_q;
  logic [CW-1:0]              rcnt_q;

  logic [CW-1:0]              count_q, count_d;
  logic [CW-1:0]              rptr_q, rptr_d;
  logic [CW-1:0]              wptr_q, wptr_d;
  logic [CW-1:0]              n_q, n_d;
  logic [AW-1:0]              paddr_q, paddr_d;
  logic [AW-1:0]              slot_q, slot_d;
  logic                       pend_q, pend_d;

  logic                       done_q;
  logic [DATA_WIDTH-1:0]      rdata_q;
  logic [CW-1:0]              total_q;
  logic [1:0]                 status_q;

  logic                       we;
  logic [AW-1:0]              waddr;
  logic [DATA_WIDTH-1:0]      wdata;
  logic                       re;
  logic [AW-1:0]              raddr;

  logic [CW-1:0]              avail;
  logic [CW-1:0]              n_calc;
  logic [CW-1:0]              rptr_dec;
  logic                       hit;
  logic                       sr_done;
  logic                       sh_done;
  logic                       mv_done;

  assign avail    = count_q - pos_q + CW'(1);
  assign n_calc   = (rcnt_q < avail) ? rcnt_q : avail;
  assign rptr_dec = rptr_q - CW'(1);
  assign hit      = pend_q && (mem_rd_q == match_q);
  assign sr_done  = hit || (rptr_q == '0);
  assign sh_done  = (rptr_q == CW'(slot_q)) && !pend_q;
  assign mv_done  = (rptr_q >= count_q) && !pend_q;

  always_comb begin
    stat_o.func    = func_q;
    stat_o.full    = (count_q == CW'(DEPTH));
    stat_o.empty   = (count_q == '0);
    stat_o.rd_ok   = (pos_q < count_q);
    stat_o.rm_bad  = (pos_q == '0) || (pos_q > count_q);
    stat_o.rm_none = (rcnt_q == '0);
    stat_o.mv_done = mv_done;
    stat_o.sr_done = sr_done;
    stat_o.sh_done = sh_done;
  end

  always_comb begin
    count_d = count_q;
    rptr_d  = rptr_q;
    wptr_d  = wptr_q;
    n_d     = n_q;
    paddr_d = paddr_q;
    slot_d  = slot_q;
    pend_d  = pend_q;
    we      = 1'b0;
    waddr   = count_q[AW-1:0];
    wdata   = value_q;
    re      = 1'b0;
    raddr   = rptr_dec[AW-1:0];
    unique case (cmd_i.op)
      sre_pkg::OP_PUSH: begin
        we      = 1'b1;
        waddr   = count_q[AW-1:0];
        wdata   = value_q;
        count_d = count_q + CW'(1);
      end
      sre_pkg::OP_POP: begin
        count_d = count_q - CW'(1);
      end
      sre_pkg::OP_RD_ISSUE: begin
        re    = 1'b1;
        raddr = pos_q[AW-1:0];
      end
      sre_pkg::OP_RM_SETUP: begin
        rptr_d = avail;
        wptr_d = avail - n_calc;
        n_d    = n_calc;
        pend_d = 1'b0;
      end
      sre_pkg::OP_RM_STEP: begin
        if (rptr_q < count_q) begin
          re     = 1'b1;
          raddr  = rptr_q[AW-1:0];
          rptr_d = rptr_q + CW'(1);
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          we     = 1'b1;
          waddr  = wptr_q[AW-1:0];
          wdata  = mem_rd_q;
          wptr_d = wptr_q + CW'(1);
        end
        if (mv_done) begin
          count_d = count_q - n_q;
        end
      end
      sre_pkg::OP_SR_SETUP: begin
        rptr_d = count_q;
        pend_d = 1'b0;
      end
      sre_pkg::OP_SR_STEP: begin
        if (sr_done) begin
          slot_d = hit ? (paddr_q + AW'(1)) : '0;
          rptr_d = count_q;
          pend_d = 1'b0;
        end else begin
          re      = 1'b1;
          raddr   = rptr_dec[AW-1:0];
          rptr_d  = rptr_dec;
          paddr_d = rptr_dec[AW-1:0];
          pend_d  = 1'b1;
        end
      end
      sre_pkg::OP_SH_STEP: begin
        if (rptr_q > CW'(slot_q)) begin
          re      = 1'b1;
          raddr   = rptr_dec[AW-1:0];
          rptr_d  = rptr_dec;
          paddr_d = rptr_dec[AW-1:0];
          pend_d  = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          we    = 1'b1;
          waddr = paddr_q + AW'(1);
          wdata = mem_rd_q;
        end
      end
      sre_pkg::OP_PLACE: begin
        we      = 1'b1;
        waddr   = slot_q;
        wdata   = value_q;
        count_d = count_q + CW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      mem_rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      rptr_q  <= '0;
      wptr_q  <= '0;
      n_q     <= '0;
      paddr_q <= '0;
      slot_q  <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      rptr_q  <= rptr_d;
      wptr_q  <= wptr_d;
      n_q     <= n_d;
      paddr_q <= paddr_d;
      slot_q  <= slot_d;
      pend_q  <= pend_d;
      done_q  <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == sre_pkg::OP_LOAD) begin
      func_q  <= func_i;
      value_q <= value_i;
      match_q <= match_value_i;
      pos_q   <= position_i;
      rcnt_q  <= remove_count_i;
    end
    if (cmd_i.finish) begin
      rdata_q  <= cmd_i.use_rdata ? mem_rd_q : '0;
      total_q  <= count_d;
      status_q <= cmd_i.code;
    end
  end

  assign done_o        = done_q;
  assign read_data_o   = rdata_q;
  assign entry_total_o = total_q;
  assign status_o      = status_q;

`ifndef ASSERT_OFF
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("Result strobe held for more than one cycle.");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == sre_pkg::OP_PUSH) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("Push did not advance the entry count by one.");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CW'(DEPTH)))
    else $error("Entry count exceeds the store depth.");

  a_remove_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd_i.op == sre_pkg::OP_RM_STEP) && pend_q) |-> (wptr_q < rptr_q))
    else $error("Range removal writes at or above its read pointer.");
`endif

endmodule

/* src/sre_controller.sv */
// Controller state machine that sequences each transaction through the datapath.
`timescale 1ns / 1ps

module sre_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  sre_pkg::dp_stat_t stat_i,
  output sre_pkg::dp_cmd_t  cmd_o
);

  sre_pkg::ctl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sre_pkg::S_IDLE: begin
        if (start) begin
          state_d = sre_pkg::S_DECIDE;
        end
      end
      sre_pkg::S_DECIDE: begin
        state_d = sre_pkg::S_IDLE;
        unique case (stat_i.func)
          sre_pkg::FUNC_READ: begin
            if (stat_i.rd_ok) begin
              state_d = sre_pkg::S_RD_WAIT;
            end
          end
          sre_pkg::FUNC_REMOVE: begin
            if (!stat_i.rm_bad && !stat_i.rm_none) begin
              state_d = sre_pkg::S_REMOVE;
            end
          end
          sre_pkg::FUNC_INSERT: begin
            if (!stat_i.full) begin
              state_d = sre_pkg::S_SEARCH;
            end
          end
          default: begin
          end
        endcase
      end
      sre_pkg::S_RD_WAIT: begin
        state_d = sre_pkg::S_IDLE;
      end
      sre_pkg::S_REMOVE: begin
        if (stat_i.mv_done) begin
          state_d = sre_pkg::S_IDLE;
        end
      end
      sre_pkg::S_SEARCH: begin
        if (stat_i.sr_done) begin
          state_d = sre_pkg::S_SHIFT;
        end
      end
      sre_pkg::S_SHIFT: begin
        if (stat_i.sh_done) begin
          state_d = sre_pkg::S_PLACE;
        end
      end
      sre_pkg::S_PLACE: begin
        state_d = sre_pkg::S_IDLE;
      end
      default: begin
        state_d = sre_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o.op        = sre_pkg::OP_NONE;
    cmd_o.finish    = 1'b0;
    cmd_o.code      = sre_pkg::ST_OK;
    cmd_o.use_rdata = 1'b0;
    unique case (state_q)
      sre_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.op = sre_pkg::OP_LOAD;
        end
      end
      sre_pkg::S_DECIDE: begin
        unique case (stat_i.func)
          sre_pkg::FUNC_PUSH: begin
            cmd_o.finish = 1'b1;
            if (stat_i.full) begin
              cmd_o.code = sre_pkg::ST_FULL;
            end else begin
              cmd_o.op = sre_pkg::OP_PUSH;
            end
          end
          sre_pkg::FUNC_POP: begin
            cmd_o.finish = 1'b1;
            if (stat_i.empty) begin
              cmd_o.code = sre_pkg::ST_EMPTY;
            end else begin
              cmd_o.op = sre_pkg::OP_POP;
            end
          end
          sre_pkg::FUNC_READ: begin
            if (stat_i.rd_ok) begin
              cmd_o.op = sre_pkg::OP_RD_ISSUE;
            end else begin
              cmd_o.finish = 1'b1;
              cmd_o.code   = sre_pkg::ST_RANGE;
            end
          end
          sre_pkg::FUNC_REMOVE: begin
            if (stat_i.rm_bad) begin
              cmd_o.finish = 1'b1;
              cmd_o.code   = sre_pkg::ST_RANGE;
            end else if (stat_i.rm_none) begin
              cmd_o.finish = 1'b1;
            end else begin
              cmd_o.op = sre_pkg::OP_RM_SETUP;
            end
          end
          sre_pkg::FUNC_INSERT: begin
            if (stat_i.full) begin
              cmd_o.finish = 1'b1;
              cmd_o.code   = sre_pkg::ST_FULL;
            end else begin
              cmd_o.op = sre_pkg::OP_SR_SETUP;
            end
          end
          default: begin
            cmd_o.finish = 1'b1;
          end
        endcase
      end
      sre_pkg::S_RD_WAIT: begin
        cmd_o.finish    = 1'b1;
        cmd_o.use_rdata = 1'b1;
      end
      sre_pkg::S_REMOVE: begin
        cmd_o.op     = sre_pkg::OP_RM_STEP;
        cmd_o.finish = stat_i.mv_done;
      end
      sre_pkg::S_SEARCH: begin
        cmd_o.op = sre_pkg::OP_SR_STEP;
      end
      sre_pkg::S_SHIFT: begin
        cmd_o.op = sre_pkg::OP_SH_STEP;
      end
      sre_pkg::S_PLACE: begin
        cmd_o.op     = sre_pkg::OP_PLACE;
        cmd_o.finish = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sre_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != sre_pkg::S_IDLE);

endmodule

/* src/stack_with_range_edit.sv */
// Top level of the bounded stack with indexed read, range removal and insert above match.
//
//   Channel   Direction  Handshake               Payload
//   command   in         start high, busy low    func_i, value_i, position_i,
//                                                remove_count_i, match_value_i
//   result    out        done_o for one cycle    read_data_o, entry_total_o, status_o
//
// Push, pop, unused codes and rejected transactions finish in the decide state; a read
// finishes after a store-read wait state. A range removal moves the entries above the range
// down; an insert searches down from the top for the match, shifts the entries above it up
// and places the value. The store takes one read and one write per cycle.
// Reset clears the entry count and the controller; the entry store is not cleared.
// Results cannot be stalled; each appears on done_o for exactly one cycle.
`timescale 1ns / 1ps

module stack_with_range_edit #(
  parameter int DEPTH      = sre_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = sre_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [sre_pkg::FUNC_W-1:0]   func_i,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  input  logic [$clog2(DEPTH+1)-1:0]   position_i,
  input  logic [$clog2(DEPTH+1)-1:0]   remove_count_i,
  input  logic signed [DATA_WIDTH-1:0] match_value_i,
  output logic                         done_o,
  output logic signed [DATA_WIDTH-1:0] read_data_o,
  output logic [$clog2(DEPTH+1)-1:0]   entry_total_o,
  output logic [1:0]                   status_o
);

  sre_pkg::dp_cmd_t  cmd;
  sre_pkg::dp_stat_t stat;

  sre_controller u_ctl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  sre_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .func_i         (func_i),
    .value_i        (value_i),
    .position_i     (position_i),
    .remove_count_i (remove_count_i),
    .match_value_i  (match_value_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .done_o         (done_o),
    .read_data_o    (read_data_o),
    .entry_total_o  (entry_total_o),
    .status_o       (status_o)
  );

endmodule
